// ----- rtl/core/dcc_pkg.sv -----
// ----------------------------------------------------------------------------
// dcc_pkg: shared definitions for the distinct context counter
// Sizes, register indexes, state encodings and the set lookup interface.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int SET_SIZE  = 2048;
	localparam int MAX_DEPTH = 6;

	localparam int IDX_W   = $clog2(SET_SIZE);
	localparam int CNT_W   = $clog2(SET_SIZE + 1);
	localparam int COUNT_W = 12;
	localparam int DEPTH_W = 3;
	localparam int HASH_W  = 8 * MAX_DEPTH + 1;

	// configuration register indexes
	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_DEPTH  = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_REQ,
		ST_WAIT
	} ctl_state_t;

	typedef enum logic [0:0] {
		SS_IDLE,
		SS_SCAN
	} set_state_t;

	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} set_req_t;

	typedef struct packed {
		logic done;
		logic inserted;
		logic full;
	} set_rsp_t;

	// clamp the programmed depth into 1..MAX_DEPTH
	function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
		logic [DEPTH_W-1:0] r;
		r = d;
		if (d == '0)
			r = DEPTH_W'(1);
		else if (d > DEPTH_W'(MAX_DEPTH))
			r = DEPTH_W'(MAX_DEPTH);
		return r;
	endfunction

endpackage

// ----- rtl/core/dcc_set.sv -----
// ----------------------------------------------------------------------------
// dcc_set: hash set of context hashes
// Scans the stored hashes one per cycle through a synchronous memory and
// appends the hash at the end when it is absent and the set has room.
// ----------------------------------------------------------------------------
module dcc_set (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dcc_pkg::set_req_t        req,
	output dcc_pkg::set_rsp_t        rsp,
	output logic [dcc_pkg::CNT_W-1:0] entries
);
	import dcc_pkg::*;

	logic [HASH_W-1:0] mem [SET_SIZE];

	set_state_t        state_q, state_d;
	logic [HASH_W-1:0] key_q;
	logic [CNT_W-1:0]  entries_q;
	logic [CNT_W-1:0]  iss_q;
	logic              vld_s1;
	logic [HASH_W-1:0] rd_data_s1;

	logic match;
	logic issue;
	logic scan_end;
	logic room;
	logic wr_en;

	assign match    = vld_s1 && (rd_data_s1 == key_q);
	assign issue    = (state_q == SS_SCAN) && (iss_q < entries_q) && !match;
	assign scan_end = (state_q == SS_SCAN) && (iss_q == entries_q) && !vld_s1;
	assign room     = entries_q < CNT_W'(SET_SIZE);
	assign wr_en    = scan_end && room;
	assign entries  = entries_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SS_IDLE: begin
				if (req.valid)
					state_d = SS_SCAN;
			end
			SS_SCAN: begin
				if (match || scan_end)
					state_d = SS_IDLE;
			end
			default: state_d = SS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.done     = (state_q == SS_SCAN) && (match || scan_end);
		rsp.inserted = !match && wr_en;
		rsp.full     = !match && scan_end && !room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SS_IDLE;
			entries_q <= '0;
			iss_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_q == SS_IDLE)
				iss_q <= '0;
			else if (issue)
				iss_q <= iss_q + 1'b1;
			if (wr_en && !match)
				entries_q <= entries_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SS_IDLE && req.valid)
			key_q <= req.hash;
	end

	// one write port and one read port: append on insert, registered read at the scan address
	always_ff @(posedge clk) begin
		if (wr_en && !match)
			mem[entries_q[IDX_W-1:0]] <= key_q;
		rd_data_s1 <= mem[iss_q[IDX_W-1:0]];
	end

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q <= CNT_W'(SET_SIZE))
		else $error("set entry count beyond capacity");

	a_no_issue_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> iss_q < entries_q)
		else $error("read issued past the stored entries");

	a_done_leaves_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> state_q == SS_IDLE)
		else $error("scan did not end after response");

endmodule

// ----- rtl/core/distinct_context_counter.sv -----
// ----------------------------------------------------------------------------
// distinct_context_counter: distinct contexts before a target byte
// Hashes the bytes preceding each target byte and counts distinct hashes.
//
//   channel   signals                           handshake
//   input     start, busy, data_byte            start && !busy
//   result    done, distinct_count, context_*,  one-cycle done strobe
//             set_full
//   config    cfg_valid, cfg_ready, cfg_index,  cfg_valid && cfg_ready
//             cfg_data
//
// A byte that does not check a context answers in the cycle after acceptance.
// A checked byte goes through hashing, one step per context byte, a request
// state and a scan of the set memory at one entry per cycle through its
// single read port. Reset clears the history, the fill count and the
// registers; the set memory needs no clearing pass. Results cannot be
// stalled by the receiver.
// ----------------------------------------------------------------------------
module distinct_context_counter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [7:0]                 data_byte,
	output logic                       done,
	output logic [dcc_pkg::COUNT_W-1:0] distinct_count,
	output logic                       context_checked,
	output logic                       context_new,
	output logic                       set_full,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [7:0]                 cfg_data
);
	import dcc_pkg::*;

	ctl_state_t         state_q, state_d;
	logic [7:0]         target_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [7:0]         hist_q [MAX_DEPTH];
	logic [7:0]         snap_q [MAX_DEPTH];
	logic [DEPTH_W-1:0] seen_q;
	logic [DEPTH_W-1:0] steps_q;
	logic [HASH_W-1:0]  hash_q;
	logic               done_q;
	logic               checked_q;
	logic               new_q;
	logic               full_q;

	logic               accept;
	logic               hit;
	logic [DEPTH_W-1:0] depth_eff;
	set_req_t           req;
	set_rsp_t           rsp;
	logic [CNT_W-1:0]   entries;

	assign cfg_ready = 1'b1;
	assign depth_eff = eff_depth(depth_q);
	assign accept    = start && !busy;
	assign hit       = (data_byte == target_q) && (seen_q >= depth_eff);

	dcc_set u_set (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.entries (entries)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && hit)
					state_d = ST_HASH;
			end
			ST_HASH: begin
				if (steps_q == DEPTH_W'(1))
					state_d = ST_REQ;
			end
			ST_REQ:  state_d = ST_WAIT;
			ST_WAIT: begin
				if (rsp.done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = state_q != ST_IDLE;
		req.valid = state_q == ST_REQ;
		req.hash  = hash_q;
	end

	assign done            = done_q;
	assign distinct_count  = COUNT_W'(entries);
	assign context_checked = checked_q;
	assign context_new     = new_q;
	assign set_full        = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			target_q  <= 8'd32;
			depth_q   <= DEPTH_W'(1);
			seen_q    <= '0;
			done_q    <= 1'b0;
			checked_q <= 1'b0;
			new_q     <= 1'b0;
			full_q    <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++)
				hist_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TARGET: target_q <= cfg_data;
					REG_DEPTH:  depth_q  <= cfg_data[DEPTH_W-1:0];
					default:    ;
				endcase
			end
			if (accept) begin
				// shift the new byte in; the hash works from the snapshot
				for (int i = MAX_DEPTH - 1; i > 0; i--)
					hist_q[i] <= hist_q[i-1];
				hist_q[0] <= data_byte;
				if (seen_q < DEPTH_W'(MAX_DEPTH))
					seen_q <= seen_q + 1'b1;
			end
			if (accept && !hit) begin
				done_q    <= 1'b1;
				checked_q <= 1'b0;
				new_q     <= 1'b0;
				full_q    <= 1'b0;
			end else if (state_q == ST_WAIT && rsp.done) begin
				done_q    <= 1'b1;
				checked_q <= 1'b1;
				new_q     <= rsp.inserted;
				full_q    <= rsp.full;
			end else begin
				done_q    <= 1'b0;
			end
		end
	end

	// hash datapath: one multiply-by-257 step per cycle, most recent byte first
	always_ff @(posedge clk) begin
		if (accept) begin
			snap_q  <= hist_q;
			hash_q  <= '0;
			steps_q <= depth_eff;
		end else if (state_q == ST_HASH) begin
			hash_q  <= (hash_q << 8) + hash_q + HASH_W'(snap_q[0]) + HASH_W'(1);
			steps_q <= steps_q - 1'b1;
			for (int i = 0; i < MAX_DEPTH - 1; i++)
				snap_q[i] <= snap_q[i+1];
			snap_q[MAX_DEPTH-1] <= '0;
		end
	end

	a_new_is_checked: assert property (@(posedge clk) disable iff (!arst_n)
		done && (context_new || set_full) |-> context_checked)
		else $error("insert or drop flagged without a checked context");

	a_new_excl_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(context_new && set_full))
		else $error("context both inserted and dropped");

	a_new_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && context_new |-> distinct_count == COUNT_W'($past(distinct_count) + 1'b1))
		else $error("insert did not advance the distinct count");

	a_req_only_hashed: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> $past(state_q) == ST_HASH)
		else $error("set request without a finished hash");

endmodule

// ----- tb/sv/distinct_context_counter_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distinct_context_counter_test: self-checking bench for the context counter
// Feeds byte streams under several target/depth settings, predicts each
// result with a behavioral model of the hash set or takes it from a typed
// table row, and compares every strobed result field by field.
// ----------------------------------------------------------------------------
module distinct_context_counter_test;

	import dcc_pkg::*;

	localparam int          WATCHDOG_LIMIT = 25000;
	localparam int          DRAIN_CYCLES   = 2100;
	localparam int          RANDOM_PHASES  = 5;
	localparam int          PHASE_ITEMS    = 55;
	localparam logic [1:0]  REG_SPARE_A    = 2'd2;
	localparam logic [1:0]  REG_SPARE_B    = 2'd3;
	localparam int          ROW_COUNT      = 24;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               checked;
		logic               is_new;
		logic               full;
	} verdict_t;

	typedef enum logic {
		ROW_BYTE,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] index;
		logic [7:0] value;
		logic       typed;
		verdict_t   verdict;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [7:0]         data_byte;
	logic               done;
	logic [COUNT_W-1:0] distinct_count;
	logic               context_checked;
	logic               context_new;
	logic               set_full;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [7:0]         cfg_data;

	// behavioral copy of the block state
	logic [7:0]         tgt_reg;
	logic [2:0]         depth_reg;
	logic [7:0]         recent_bytes [MAX_DEPTH];
	int                 bytes_seen;
	bit                 known_keys [bit [HASH_W-1:0]];
	int                 stored_keys;

	verdict_t           context_verdicts [$];
	stim_row_t          stim_rows [ROW_COUNT];
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	int                 burst_left;

	distinct_context_counter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.data_byte       (data_byte),
		.done            (done),
		.distinct_count  (distinct_count),
		.context_checked (context_checked),
		.context_new     (context_new),
		.set_full        (set_full),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// advance the model by one byte and return what the block should report
	function automatic verdict_t judge_context(input logic [7:0] b);
		verdict_t          v;
		int                depth;
		bit [HASH_W-1:0]   key;
		v = '0;
		depth = (depth_reg == 3'd0) ? 1 : int'(depth_reg);
		if (depth > MAX_DEPTH)
			depth = MAX_DEPTH;
		if (b == tgt_reg && bytes_seen >= depth) begin
			key = '0;
			for (int k = 0; k < depth; k++)
				key = key * 257 + recent_bytes[k] + 1;
			v.checked = 1'b1;
			if (!known_keys.exists(key)) begin
				if (stored_keys < SET_SIZE) begin
					known_keys[key] = 1'b1;
					stored_keys++;
					v.is_new = 1'b1;
				end else begin
					v.full = 1'b1;
				end
			end
		end
		for (int k = MAX_DEPTH - 1; k > 0; k--)
			recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = b;
		if (bytes_seen < MAX_DEPTH)
			bytes_seen++;
		v.count = COUNT_W'(stored_keys);
		return v;
	endfunction

	// one byte transaction, with the sender's burst/gap pattern in front of it
	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input verdict_t typed_v = '0);
		int       gap;
		verdict_t v;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				start = 1'b0;
				data_byte = 8'($urandom);
			end
		end
		burst_left--;
		@(negedge clk);
		start = 1'b1;
		data_byte = b;
		do
			@(posedge clk);
		while (busy);
		v = judge_context(b);
		context_verdicts.push_back(typed ? typed_v : v);
	endtask

	// register write, only once the block has drained
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		start = 1'b0;
		while (context_verdicts.size() != 0 || busy)
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_TARGET)
			tgt_reg = val;
		else if (idx == REG_DEPTH)
			depth_reg = val[2:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && done) begin
			if (context_verdicts.size() == 0) begin
				flag_mismatch($sformatf("unexpected result count=%0d chk=%b new=%b full=%b",
					distinct_count, context_checked, context_new, set_full));
			end else begin
				exp_v = context_verdicts.pop_front();
				if (distinct_count !== exp_v.count || context_checked !== exp_v.checked ||
						context_new !== exp_v.is_new || set_full !== exp_v.full)
					flag_mismatch($sformatf(
						"count %0d/%0d chk %b/%b new %b/%b full %b/%b (exp/act)",
						exp_v.count, distinct_count, exp_v.checked, context_checked,
						exp_v.is_new, context_new, exp_v.full, set_full));
			end
		end
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [7:0] sym_a;
		logic [7:0] sym_b;
		logic [7:0] b;
		int         r;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		tgt_reg = 8'd32;
		depth_reg = 3'd1;
		bytes_seen = 0;
		stored_keys = 0;
		for (int k = 0; k < MAX_DEPTH; k++)
			recent_bytes[k] = '0;

		// reset state: target 32, depth 1
		stim_rows[0]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd0, 1'b0, 1'b0, 1'b0}};
		stim_rows[1]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd1, 1'b1, 1'b1, 1'b0}};
		stim_rows[2]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd1, 1'b1, 1'b0, 1'b0}};
		stim_rows[3]  = '{ROW_BYTE, 2'd0, 8'd0,   1'b1, '{12'd1, 1'b0, 1'b0, 1'b0}};
		stim_rows[4]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd2, 1'b1, 1'b1, 1'b0}};
		stim_rows[5]  = '{ROW_BYTE, 2'd0, 8'd255, 1'b1, '{12'd2, 1'b0, 1'b0, 1'b0}};
		stim_rows[6]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd3, 1'b1, 1'b1, 1'b0}};
		// depth zero behaves as one
		stim_rows[7]  = '{ROW_REG,  REG_DEPTH, 8'd0, 1'b0, '0};
		stim_rows[8]  = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd3, 1'b1, 1'b0, 1'b0}};
		// depth seven clamps to six
		stim_rows[9]  = '{ROW_REG,  REG_DEPTH, 8'd7, 1'b0, '0};
		stim_rows[10] = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd4, 1'b1, 1'b1, 1'b0}};
		// writes to unused indexes must leave both registers alone
		stim_rows[11] = '{ROW_REG,  REG_SPARE_A, 8'h00, 1'b0, '0};
		stim_rows[12] = '{ROW_REG,  REG_SPARE_B, 8'hFF, 1'b0, '0};
		stim_rows[13] = '{ROW_BYTE, 2'd0, 8'd32,  1'b1, '{12'd5, 1'b1, 1'b1, 1'b0}};
		stim_rows[14] = '{ROW_REG,  REG_TARGET, 8'd0, 1'b0, '0};
		// upper data bits of a depth write are dropped
		stim_rows[15] = '{ROW_REG,  REG_DEPTH, 8'hF9, 1'b0, '0};
		stim_rows[16] = '{ROW_BYTE, 2'd0, 8'd0,   1'b1, '{12'd5, 1'b1, 1'b0, 1'b0}};
		stim_rows[17] = '{ROW_BYTE, 2'd0, 8'd0,   1'b1, '{12'd5, 1'b1, 1'b0, 1'b0}};
		stim_rows[18] = '{ROW_REG,  REG_TARGET, 8'd255, 1'b0, '0};
		stim_rows[19] = '{ROW_BYTE, 2'd0, 8'd255, 1'b1, '{12'd5, 1'b1, 1'b0, 1'b0}};
		stim_rows[20] = '{ROW_REG,  REG_DEPTH, 8'd6, 1'b0, '0};
		stim_rows[21] = '{ROW_BYTE, 2'd0, 8'd255, 1'b0, '0};
		stim_rows[22] = '{ROW_BYTE, 2'd0, 8'd128, 1'b0, '0};
		stim_rows[23] = '{ROW_BYTE, 2'd0, 8'd255, 1'b0, '0};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_REG)
				write_reg(stim_rows[i].index, stim_rows[i].value);
			else
				push_byte(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].verdict);
		end

		// random phases: small alphabet around the target so contexts repeat
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: write_reg(REG_TARGET, 8'd0);
				1: write_reg(REG_TARGET, 8'd255);
				default: write_reg(REG_TARGET, 8'($urandom));
			endcase
			write_reg(REG_DEPTH, 8'($urandom));
			if ($urandom_range(0, 1) == 1)
				write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
					8'($urandom));
			sym_a = 8'($urandom);
			sym_b = 8'($urandom);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					b = tgt_reg;
				else if (r < 60)
					b = sym_a;
				else if (r < 85)
					b = sym_b;
				else
					b = 8'($urandom);
				push_byte(b);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (context_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && context_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- distinct_context_counter.f -----
rtl/core/dcc_pkg.sv
rtl/core/dcc_set.sv
rtl/core/distinct_context_counter.sv
tb/sv/distinct_context_counter_test.sv
